/* rtl/multitouch_dial_slot_tracker_unit_assert.svh */
// Assertion macros shared by the slot tracker modules.
`ifndef MULTITOUCH_DIAL_SLOT_TRACKER_UNIT_ASSERT_SVH
`define MULTITOUCH_DIAL_SLOT_TRACKER_UNIT_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle.
`define MDST_ASSERT_IMP(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define MDST_ASSERT_NXT(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/mdst_pkg.sv */
// Shared types, constants and helper functions of the slot tracker.
`default_nettype none
package mdst_pkg;
  localparam int NSLOTS = 16;
  localparam int SW = $clog2(NSLOTS);
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [1:0] {PH_NONE = 2'd0, PH_BEGIN = 2'd1, PH_UPDATE = 2'd2,
                            PH_END = 2'd3} phase_t;
  typedef enum logic [1:0] {REQ_ABS = 2'd0, REQ_SYNC = 2'd1, REQ_OTHER = 2'd2,
                            REQ_RSVD = 2'd3} req_t;
  typedef enum logic [2:0] {AC_SLOT = 3'd0, AC_TRACK = 3'd1, AC_X = 3'd2,
                            AC_Y = 3'd3, AC_MAJOR = 3'd4, AC_MINOR = 3'd5,
                            AC_ORIENT = 3'd6, AC_OTHER = 3'd7} abs_code_t;
  typedef enum logic [2:0] {RK_PROX_IN = 3'd0, RK_TIP_DOWN = 3'd1, RK_AXIS = 3'd2,
                            RK_TIP_UP = 3'd3, RK_PROX_OUT = 3'd4,
                            RK_TOUCH = 3'd5} report_kind_t;
  typedef enum logic [2:0] {BK_IDLE, BK_SCAN, BK_EMIT1, BK_EMIT2, BK_FINAL,
                            BK_DIV} bk_state_t;
  localparam int REG_SLOT_COUNT = 0;
  localparam int REG_MAJOR_RES = 1;
  localparam int REG_MINOR_RES = 2;
  localparam logic [4:0] ALL_MARKS = 5'h1f;

  // One queued command from the front part to the back part.
  typedef struct packed {
    logic        is_sync;
    logic [2:0]  code;
    logic [31:0] value;
  } cmd_t;
endpackage
`default_nettype wire

/* rtl/multitouch_dial_slot_tracker_unit.sv */
// Top level of the multitouch dial slot tracker.
// Usage:
//  - Input channel: push an item (in_req_type, in_abs_code, in_event_value)
//    while in_full is low. Absolute events update the selected slot; a sync
//    item starts a walk of the slots.
//  - Result channel: while out_empty is low the oldest report is on the
//    out_ ports; pop takes it. A stalled receiver holds the walk, and the
//    front queue (4 items) keeps taking items until it fills.
//  - Configuration: cfg_we writes register cfg_index (0 slot count,
//    1 major resolution, 2 minor resolution) at once; write while idle.
//  - Timing: an absolute event is applied by the back end when it is taken
//    from the queue. A sync walk scans the slots in turn; a reported slot
//    first waits for both 24-bit size dividers, then emits its one or two
//    reports, and the walk ends with one touch-state report.
//  - Reset (rst_n low, synchronous) clears all slot state, empties the
//    queue and the report register, and loads registers 16, 1, 1.
`default_nettype none
module multitouch_dial_slot_tracker_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [2:0]       in_abs_code,
  input  wire logic signed [31:0] in_event_value,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic [2:0]            out_report_kind,
  output logic [3:0]            out_slot_number,
  output logic signed [31:0]    out_pos_x,
  output logic signed [31:0]    out_pos_y,
  output logic [8:0]            out_rotation_deg,
  output logic [23:0]           out_size_major,
  output logic [23:0]           out_size_minor,
  output logic signed [31:0]    out_delta_x,
  output logic signed [31:0]    out_delta_y,
  output logic [4:0]            out_changed_mask,
  output logic                  out_touch_enable,
  output logic                  out_last_of_run,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);
  import mdst_pkg::*;

  logic [4:0]  slot_count_r;
  logic [15:0] major_res_r, minor_res_r;
  logic        q_valid, q_take;
  cmd_t        q_cmd;

  // hold configuration registers; writes land at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= 5'd16;
      major_res_r <= 16'd1;
      minor_res_r <= 16'd1;
    end else if (cfg_we) begin
      case (32'(cfg_index))
        REG_SLOT_COUNT: slot_count_r <= cfg_data[4:0];
        REG_MAJOR_RES:  major_res_r <= cfg_data;
        REG_MINOR_RES:  minor_res_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mdst_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_abs_code,
    .in_event_value(in_event_value), .q_valid, .q_cmd, .q_take
  );

  mdst_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take,
    .slot_count(slot_count_r), .major_res(major_res_r), .minor_res(minor_res_r),
    .out_empty, .out_pop, .out_report_kind, .out_slot_number, .out_pos_x,
    .out_pos_y, .out_rotation_deg, .out_size_major, .out_size_minor,
    .out_delta_x, .out_delta_y, .out_changed_mask, .out_touch_enable,
    .out_last_of_run
  );
endmodule
`default_nettype wire

/* rtl/mdst_front.sv */
// Front part: accepts items, drops ignored ones, queues the rest.
`default_nettype none
module mdst_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [2:0]       in_abs_code,
  input  wire logic [31:0]      in_event_value,
  output logic                  q_valid,
  output mdst_pkg::cmd_t        q_cmd,
  input  wire logic             q_take
);
  import mdst_pkg::*;
  `include "multitouch_dial_slot_tracker_unit_assert.svh"

  cmd_t            mem_r [QDEPTH];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [QAW:0]    cnt_r;
  logic            acc, keep, do_take;
  cmd_t            cmd_in;

  assign in_full = (cnt_r == (QAW+1)'(QDEPTH));
  assign acc = in_push && !in_full;
  // keep absolute events with a real code and sync frames
  assign keep = acc && ((in_req_type == REQ_SYNC) ||
                ((in_req_type == REQ_ABS) && (in_abs_code != AC_OTHER)));
  assign q_valid = (cnt_r != '0);
  assign do_take = q_take && q_valid;
  assign q_cmd = mem_r[rp_r];
  always_comb begin
    cmd_in.is_sync = (in_req_type == REQ_SYNC);
    cmd_in.code = in_abs_code;
    cmd_in.value = in_event_value;
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      mem_r[wp_r] <= cmd_in;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (keep) wp_r <= wp_r + 1'b1;
      if (do_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(keep) - (QAW+1)'(do_take);
    end
  end

  `MDST_ASSERT_IMP(a_no_overflow, clk, rst_n, keep, cnt_r < (QAW+1)'(QDEPTH), "queue overflow")
  `MDST_ASSERT_IMP(a_take_valid, clk, rst_n, q_take, q_valid, "take from empty queue")
  `MDST_ASSERT_NXT(a_cnt_step, clk, rst_n, keep && !do_take, cnt_r == $past(cnt_r) + 1'b1, "count")
endmodule
`default_nettype wire

/* rtl/mdst_div.sv */
// Restoring divider: (raw << 8) / res, one quotient bit per cycle; a zero res divides by one.
`default_nettype none
module mdst_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] raw,
  input  wire logic [15:0] res,
  output logic             busy,
  output logic [23:0]      quo
);
  import mdst_pkg::*;
  logic [23:0] num_r, q_r;
  logic [16:0] rem_r;
  logic [15:0] den_r;
  logic [4:0]  cnt_r;
  logic [16:0] trial;
  logic [16:0] sh;

  assign sh = {rem_r[15:0], num_r[23]};
  assign trial = sh - {1'b0, den_r};
  assign busy = (cnt_r != '0);
  // 24-bit quotient of a 24-bit numerator never exceeds 0xFFFFFF
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      num_r <= {raw, 8'd0};
      den_r <= (res == '0) ? 16'd1 : res;
      rem_r <= '0;
      q_r <= '0;
      cnt_r <= 5'd24;
    end else if (busy) begin
      num_r <= {num_r[22:0], 1'b0};
      if (!trial[16]) begin
        rem_r <= trial;
        q_r <= {q_r[22:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r <= {q_r[22:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule
`default_nettype wire

/* rtl/mdst_back.sv */
// Back part: slot state update and the sync walk that builds reports.
`default_nettype none
module mdst_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire mdst_pkg::cmd_t   q_cmd,
  output logic                  q_take,
  input  wire logic [4:0]       slot_count,
  input  wire logic [15:0]      major_res,
  input  wire logic [15:0]      minor_res,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic [2:0]            out_report_kind,
  output logic [3:0]            out_slot_number,
  output logic signed [31:0]    out_pos_x,
  output logic signed [31:0]    out_pos_y,
  output logic [8:0]            out_rotation_deg,
  output logic [23:0]           out_size_major,
  output logic [23:0]           out_size_minor,
  output logic signed [31:0]    out_delta_x,
  output logic signed [31:0]    out_delta_y,
  output logic [4:0]            out_changed_mask,
  output logic                  out_touch_enable,
  output logic                  out_last_of_run
);
  import mdst_pkg::*;
  `include "multitouch_dial_slot_tracker_unit_assert.svh"

  phase_t         phase_r [NSLOTS];
  logic [4:0]     marks_r [NSLOTS];
  logic [31:0]    x_r [NSLOTS], y_r [NSLOTS], ori_r [NSLOTS];
  logic [15:0]    maj_r [NSLOTS], min_r [NSLOTS];
  logic [31:0]    px_r [NSLOTS], py_r [NSLOTS];
  logic [SW-1:0]  cur_r, idx_r;
  logic           any_r;
  bk_state_t      st_r, st_nxt;

  // output register
  logic           ov_r;
  logic [2:0]     o_kind_r;
  logic [3:0]     o_slot_r;
  logic [31:0]    o_x_r, o_y_r, o_dx_r, o_dy_r;
  logic [8:0]     o_rot_r;
  logic [4:0]     o_mask_r;
  logic           o_te_r, o_last_r;
  logic [2:0]     pend_kind_r;
  logic [4:0]     pend_mask_r;
  logic           pend_delta_r, pend_two_r;

  logic [4:0]     n_act;
  logic           out_free, out_load, scan_hit;
  logic           divs_start, dj_busy, dn_busy;
  logic [23:0]    dj_q, dn_q;
  logic           last_idx;
  logic [31:0]    sel_val;
  phase_t         ph_i;

  mdst_div u_dj (.clk, .rst_n, .start(divs_start), .raw(maj_r[idx_r]),
                 .res(major_res), .busy(dj_busy), .quo(dj_q));
  mdst_div u_dn (.clk, .rst_n, .start(divs_start), .raw(min_r[idx_r]),
                 .res(minor_res), .busy(dn_busy), .quo(dn_q));

  assign n_act = (slot_count == 5'd0) ? 5'd1 :
                 (slot_count > 5'(NSLOTS)) ? 5'(NSLOTS) : slot_count;
  assign out_free = !ov_r || out_pop;
  assign out_load = out_free &&
                    (st_r == BK_EMIT1 || st_r == BK_EMIT2 || st_r == BK_FINAL);
  assign last_idx = ({1'b0, idx_r} + 5'd1 >= n_act);
  assign ph_i = phase_r[idx_r];
  assign sel_val = q_cmd.value;
  // the slot under the walk has something to report
  assign scan_hit = !(ph_i == PH_NONE || (ph_i == PH_UPDATE && marks_r[idx_r] == '0));

  // rotation = (-angle) mod 360 of the slot under the walk, in three
  // register stages; the size dividers give it far more cycles than it needs.
  // floor(|a|/360) comes from the reciprocal 0xB60B60 / 2^32, which never
  // overshoots and undershoots by at most one, so one subtract corrects it.
  logic [31:0] mag;
  logic [63:0] prod;
  logic [31:0] rot_mag_r, rot_q_r, rr;
  logic        rot_neg_r;
  logic [9:0]  rot_rr_r, rem_a;
  logic [8:0]  rot_r;

  assign mag = ori_r[idx_r][31] ? (~ori_r[idx_r] + 32'd1) : ori_r[idx_r];
  assign prod = 64'(mag) * 64'h00B60B60;
  assign rr = rot_mag_r - rot_q_r * 32'd360;
  assign rem_a = (rot_rr_r >= 10'd360) ? (rot_rr_r - 10'd360) : rot_rr_r;

  always_ff @(posedge clk) begin
    rot_mag_r <= mag;
    rot_neg_r <= ori_r[idx_r][31];
    rot_q_r <= prod[63:32];
    rot_rr_r <= rr[9:0];
    if (rem_a == 10'd0) rot_r <= 9'd0;
    else if (rot_neg_r) rot_r <= rem_a[8:0];
    else rot_r <= 9'(10'd360 - rem_a);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_valid && q_cmd.is_sync) st_nxt = BK_SCAN;
      BK_SCAN: begin
        if (!scan_hit) begin
          if (last_idx) st_nxt = BK_FINAL;
        end else begin
          st_nxt = BK_DIV;
        end
      end
      BK_DIV: if (!dj_busy && !dn_busy && !divs_start && out_free) st_nxt = BK_EMIT1;
      BK_EMIT1: if (out_free) st_nxt = pend_two_r ? BK_EMIT2 : (last_idx ? BK_FINAL : BK_SCAN);
      BK_EMIT2: if (out_free) st_nxt = last_idx ? BK_FINAL : BK_SCAN;
      BK_FINAL: if (out_free) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  assign q_take = (st_r == BK_IDLE && q_valid && !q_cmd.is_sync) ||
                  (st_r == BK_FINAL && out_free);
  logic div_go_r;
  assign divs_start = div_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      cur_r <= '0;
      idx_r <= '0;
      any_r <= 1'b0;
      ov_r <= 1'b0;
      div_go_r <= 1'b0;
      for (int i = 0; i < NSLOTS; i++) begin
        phase_r[i] <= PH_NONE;
        marks_r[i] <= '0;
        x_r[i] <= '0; y_r[i] <= '0; ori_r[i] <= '0;
        maj_r[i] <= '0; min_r[i] <= '0; px_r[i] <= '0; py_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      div_go_r <= (st_r == BK_SCAN) && scan_hit;
      if (out_load) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
      case (st_r)
        BK_IDLE: begin
          idx_r <= '0;
          any_r <= 1'b0;
          if (q_valid && !q_cmd.is_sync) begin
            case (abs_code_t'(q_cmd.code))
              AC_SLOT: cur_r <= (sel_val >= 32'(n_act)) ? SW'(n_act - 5'd1) : SW'(sel_val);
              AC_TRACK: begin
                if (!sel_val[31]) phase_r[cur_r] <= PH_BEGIN;
                else if (phase_r[cur_r] != PH_NONE) phase_r[cur_r] <= PH_END;
              end
              AC_X: begin x_r[cur_r] <= sel_val; marks_r[cur_r][0] <= 1'b1; end
              AC_Y: begin y_r[cur_r] <= sel_val; marks_r[cur_r][1] <= 1'b1; end
              AC_MAJOR: begin maj_r[cur_r] <= sel_val[15:0]; marks_r[cur_r][3] <= 1'b1; end
              AC_MINOR: begin min_r[cur_r] <= sel_val[15:0]; marks_r[cur_r][4] <= 1'b1; end
              AC_ORIENT: begin ori_r[cur_r] <= sel_val; marks_r[cur_r][2] <= 1'b1; end
              default: ;
            endcase
          end
        end
        BK_SCAN: begin
          if (!scan_hit) begin
            if (ph_i != PH_NONE) begin
              any_r <= 1'b1;
              px_r[idx_r] <= x_r[idx_r];
              py_r[idx_r] <= y_r[idx_r];
            end
            if (!last_idx) idx_r <= idx_r + 1'b1;
          end else begin
            if (ph_i == PH_BEGIN) begin
              px_r[idx_r] <= '0; py_r[idx_r] <= '0;
              pend_kind_r <= RK_PROX_IN; pend_mask_r <= ALL_MARKS;
              pend_delta_r <= 1'b0; pend_two_r <= 1'b1;
            end else if (ph_i == PH_UPDATE) begin
              pend_kind_r <= RK_AXIS; pend_mask_r <= marks_r[idx_r];
              pend_delta_r <= 1'b1; pend_two_r <= 1'b0;
            end else begin
              pend_kind_r <= RK_TIP_UP; pend_mask_r <= marks_r[idx_r];
              pend_delta_r <= 1'b0; pend_two_r <= 1'b1;
            end
          end
        end
        BK_EMIT1, BK_EMIT2: begin
          if (out_free) begin
            o_slot_r <= 4'(idx_r);
            o_x_r <= x_r[idx_r];
            o_y_r <= y_r[idx_r];
            o_rot_r <= rot_r;
            o_te_r <= 1'b0;
            o_last_r <= 1'b0;
            if (st_r == BK_EMIT1) begin
              o_kind_r <= pend_kind_r;
              o_mask_r <= pend_mask_r;
              o_dx_r <= pend_delta_r ? px_r[idx_r] - x_r[idx_r] : '0;
              o_dy_r <= pend_delta_r ? py_r[idx_r] - y_r[idx_r] : '0;
            end else begin
              o_kind_r <= (pend_kind_r == RK_PROX_IN) ? RK_TIP_DOWN : RK_PROX_OUT;
              o_mask_r <= '0;
              o_dx_r <= '0;
              o_dy_r <= '0;
            end
            if (st_nxt != BK_EMIT2) begin
              // finish this slot: commit phase, snapshot position, clear marks
              if (phase_r[idx_r] == PH_END) phase_r[idx_r] <= PH_NONE;
              else begin
                phase_r[idx_r] <= PH_UPDATE;
                any_r <= 1'b1;
              end
              px_r[idx_r] <= x_r[idx_r];
              py_r[idx_r] <= y_r[idx_r];
              marks_r[idx_r] <= '0;
              if (!last_idx) idx_r <= idx_r + 1'b1;
            end
          end
        end
        BK_FINAL: begin
          if (out_free) begin
            o_kind_r <= RK_TOUCH;
            o_slot_r <= '0; o_x_r <= '0; o_y_r <= '0; o_rot_r <= '0;
            o_dx_r <= '0; o_dy_r <= '0; o_mask_r <= '0;
            o_te_r <= !any_r;
            o_last_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // sizes are latched with the report
  logic [23:0] o_smaj_r, o_smin_r;
  always_ff @(posedge clk) begin
    if ((st_r == BK_EMIT1 || st_r == BK_EMIT2) && out_free) begin
      o_smaj_r <= dj_q;
      o_smin_r <= dn_q;
    end else if (st_r == BK_FINAL && out_free) begin
      o_smaj_r <= '0;
      o_smin_r <= '0;
    end
  end

  assign out_empty = !ov_r;
  assign out_report_kind = o_kind_r;
  assign out_slot_number = o_slot_r;
  assign out_pos_x = o_x_r;
  assign out_pos_y = o_y_r;
  assign out_rotation_deg = o_rot_r;
  assign out_size_major = o_smaj_r;
  assign out_size_minor = o_smin_r;
  assign out_delta_x = o_dx_r;
  assign out_delta_y = o_dy_r;
  assign out_changed_mask = o_mask_r;
  assign out_touch_enable = o_te_r;
  assign out_last_of_run = o_last_r;

  `MDST_ASSERT_IMP(a_rot_range, clk, rst_n, st_r == BK_EMIT1, rot_r < 9'd360 && rem_a < 10'd360, "rotation range")
  `MDST_ASSERT_NXT(a_no_overwrite, clk, rst_n, ov_r && !out_pop, ov_r && $stable(o_kind_r), "report overwritten")
  `MDST_ASSERT_IMP(a_last_touch, clk, rst_n, ov_r && o_last_r, o_kind_r == RK_TOUCH, "last flag off touch")
endmodule
`default_nettype wire
